### rtl/ppsm_pkg.sv
// Shared types, constants and helper functions of the pulse period speed meter.
package ppsm_pkg;

  // Capture ring and walk sizing.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MAX_WALK   = 64;
  localparam int WALK_W     = $clog2(MAX_WALK + 1);
  localparam int OFF_W      = WALK_W + 2;

  // Datapath widths.
  localparam int CNT_W  = 8;
  localparam int TOT_W  = 40;
  localparam int PROD_W = 64;
  localparam int DIV_W  = 64;

  // Fixed numeric constants.
  localparam logic [31:0] DUP_TICKS  = 32'd4;
  localparam logic [31:0] ROLL_TICKS = 32'd29999;
  localparam logic [39:0] OUT_MAX    = 40'hFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK    = 3'd7;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_NEW    = 3'd1,
    ST_STOPPED   = 3'd2,
    ST_STALE     = 3'd3,
    ST_UNSTOPPED = 3'd4,
    ST_NO_DELTAS = 3'd5,
    ST_BAD       = 3'd6
  } status_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_RD1, S_RDMIN, S_DECIDE, S_WINIT, S_WSTEP,
    S_PK_TMP, S_PK_FN, S_PK_LO, S_PK_HI, S_PK_CMP, S_PK_KH, S_PK_KL,
    S_PK_DIV, S_PK_WAIT, S_PK_SET, S_PK_END,
    S_FIX, S_CHK, S_FMUL, S_FDIV, S_FWAIT, S_SPH, S_SPL, S_FOUT, S_EMIT
  } state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_START, OP_LATCH_V, OP_DECIDE, OP_WALK_INIT,
    OP_WALK_STEP, OP_PK_TMP, OP_PK_FN, OP_PK_LO, OP_PK_HI, OP_PK_CMP,
    OP_PK_KH, OP_PK_KL, OP_PK_DIV, OP_PK_SET, OP_FIX, OP_CHK, OP_FMUL,
    OP_FDIV, OP_SPH, OP_SPL, OP_FOUT, OP_EMIT
  } op_t;

  // Ring read address selection.
  typedef enum logic [2:0] {
    RD_BACK1, RD_BACK2, RD_BACKMIN, RD_WALK, RD_WALK_NEXT
  } rd_sel_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic dec_walk;
    logic want_zero;
    logic walk_cont;
    logic pick_now;
    logic pick_direct;
    logic walk_more;
    logic n_zero;
    logic total_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  // True when x is more than 1.8 times y.
  function automatic logic outlier(input logic [31:0] x, input logic [31:0] y);
    logic [35:0] x5;
    logic [35:0] y9;
    x5 = {4'b0, x} + {2'b0, x, 2'b0};
    y9 = {4'b0, y} + {1'b0, y, 3'b0};
    return x5 > y9;
  endfunction

endpackage

### rtl/ppsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ppsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/ppsm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ppsm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppsm_pkg::DIV_W-1:0]    dividend,
  input  logic [ppsm_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [ppsm_pkg::DIV_W-1:0]    quot,
  output logic [ppsm_pkg::DIV_W-1:0]    rem
);
  import ppsm_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and test the divisor against it.
  always_comb begin
    trial = {rem, quot[DIV_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Control: count iterations and pulse done at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], fits};
      rem  <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
    end
  end

endmodule

### rtl/ppsm_dp.sv
// Datapath: configuration, capture ring, walk arithmetic, multiplier, divider and output register.
module ppsm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ppsm_pkg::cmd_t                    cmd,
  output ppsm_pkg::sts_t                    sts,
  input  logic [63:0]                       in_data,
  input  logic                              cfg_we,
  input  logic [ppsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppsm_pkg::status_t                 out_status,
  output logic [79:0]                       out_data
);
  import ppsm_pkg::*;

  // Configuration registers.
  logic [31:0] ratio, tick_hz;
  logic [15:0] timeout, low_rate, high_rate;
  logic        var_en;
  logic [6:0]  min_cnt, max_cnt;

  // Persistent state.
  logic [RING_AW-1:0]    wp;
  logic [RING_DEPTH-1:0] ring_vld;
  logic                  stopped;
  logic [31:0]           last_cap, last_ms;

  // Evaluation registers.
  logic [31:0]       now_r, v_r, cur_a, delta, last, last2;
  logic [CNT_W-1:0]  n_r, want;
  logic [WALK_W-1:0] walk_idx;
  logic [TOT_W-1:0]  total, tmp, fn_r;
  logic [55:0]       lo_r, num, den;
  logic [6:0]        k_r;
  logic              up_r;
  logic [31:0]       kh;
  logic [PROD_W-1:0] prod, ph, freq_q;
  status_t           res_status;
  logic [39:0]       res_speed, res_freq;
  logic [39:0]       out_speed, out_freq;

  // Ring access.
  logic [RING_AW-1:0] raddr;
  logic [OFF_W-1:0]   roff;
  logic [31:0]        ram_q, entry;
  logic               rd_vld;

  always_comb begin
    case (cmd.rd_sel)
      RD_BACK1:     roff = OFF_W'(1);
      RD_BACK2:     roff = OFF_W'(2);
      RD_BACKMIN:   roff = OFF_W'(min_cnt) + OFF_W'(1);
      RD_WALK:      roff = OFF_W'(walk_idx) + OFF_W'(2);
      RD_WALK_NEXT: roff = OFF_W'(walk_idx) + OFF_W'(3);
      default:      roff = OFF_W'(1);
    endcase
    raddr = wp - roff[RING_AW-1:0];
  end

  ppsm_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.op == OP_CAPTURE),
    .waddr (wp),
    .wdata (in_data[31:0]),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Entries never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    rd_vld <= ring_vld[raddr];
  end
  assign entry = rd_vld ? ram_q : 32'd0;

  // Stop and stale decision for an evaluate.
  logic       elapsed_ge, dec_walk, dec_wipe, dec_stop, dec_lc_zero, dec_seen, dec_ms_now;
  status_t    dec_code;

  always_comb begin
    elapsed_ge  = (now_r - last_ms) >= {16'b0, timeout};
    dec_walk    = 1'b0;
    dec_wipe    = 1'b0;
    dec_stop    = stopped;
    dec_lc_zero = 1'b0;
    dec_seen    = 1'b0;
    dec_ms_now  = 1'b0;
    dec_code    = ST_NO_NEW;
    if (stopped) begin
      if (v_r == 32'd0) begin
        dec_code = ST_NO_NEW;
      end else if (v_r == last_cap) begin
        dec_code    = ST_STALE;
        dec_wipe    = elapsed_ge;
        dec_lc_zero = elapsed_ge;
      end else if (entry != 32'd0) begin
        dec_stop = 1'b0;
        dec_seen = 1'b1;
        dec_walk = 1'b1;
      end else begin
        dec_seen = 1'b1;
        dec_code = ST_UNSTOPPED;
      end
    end else if (last_cap == v_r) begin
      if (elapsed_ge) begin
        dec_stop    = 1'b1;
        dec_wipe    = 1'b1;
        dec_lc_zero = 1'b1;
        dec_ms_now  = 1'b1;
        dec_code    = ST_STOPPED;
      end
    end else begin
      dec_seen = 1'b1;
      dec_walk = 1'b1;
    end
  end

  // One walk step over the pair of neighbors cur_a and entry.
  logic [31:0]      wd_diff, wd_mag, wd_new, lastm;
  logic [32:0]      wd_sum;
  logic             w_take;
  logic [TOT_W-1:0] tot1;
  logic [CNT_W-1:0] n_next, want_init;

  always_comb begin
    wd_diff = entry - cur_a;
    wd_mag  = (wd_diff > 32'h8000_0000) ? (32'd0 - wd_diff) : wd_diff;
    w_take  = (cur_a != 32'd0) && (entry != 32'd0) && (wd_mag > DUP_TICKS);
    wd_new  = (cur_a < entry) ? (ROLL_TICKS + cur_a - entry) : (cur_a - entry);
    wd_sum  = {1'b0, wd_new} + {1'b0, last2};
    tot1    = total;
    lastm   = last;
    if ((n_r == CNT_W'(2)) && outlier(last2, last) && outlier(last2, wd_new)) begin
      tot1 = total - {8'b0, last} + {8'b0, wd_new};
    end else if ((n_r > CNT_W'(2)) && outlier(last, wd_new) && outlier(last, last2)) begin
      lastm = wd_sum[32:1];
      tot1  = total - {8'b0, last} + {8'b0, wd_sum[32:1]};
    end
    n_next    = w_take ? n_r + 1'b1 : n_r;
    want_init = var_en ? ({1'b0, min_cnt} + 1'b1) : {1'b0, max_cnt};
  end

  // Sample count selection from the provisional frequency.
  logic [55:0]      hi_v;
  logic             pk_direct;
  logic [CNT_W-1:0] pk_want;
  logic [CNT_W-1:0] pk_adj;

  logic [DIV_W-1:0] div_q, div_r;
  logic             div_done;

  always_comb begin
    hi_v      = prod[55:0];
    pk_direct = 1'b1;
    pk_want   = {1'b0, min_cnt};
    if (n_r == '0) begin
      pk_want = {1'b0, min_cnt};
    end else if (tmp == '0) begin
      pk_want = {1'b0, max_cnt};
    end else if ({16'b0, fn_r} < lo_r) begin
      pk_want = {1'b0, min_cnt};
    end else if ({16'b0, fn_r} > hi_v) begin
      pk_want = {1'b0, max_cnt};
    end else if (high_rate <= low_rate) begin
      pk_want = {1'b0, min_cnt};
    end else begin
      pk_direct = 1'b0;
    end
    pk_adj = CNT_W'(div_q[6:0]) + CNT_W'(div_r != '0);
  end

  // Shared multiplier operand selection.
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [71:0] mul_full;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PK_FN, OP_FMUL: begin
        mul_a = {32'b0, n_r};
        mul_b = tick_hz;
      end
      OP_PK_LO: begin
        mul_a = tmp;
        mul_b = {16'b0, low_rate};
      end
      OP_PK_HI: begin
        mul_a = tmp;
        mul_b = {16'b0, high_rate};
      end
      OP_PK_KH: begin
        mul_a = {16'b0, num[55:32]};
        mul_b = {25'b0, k_r};
      end
      OP_PK_KL: begin
        mul_a = {8'b0, num[31:0]};
        mul_b = {25'b0, k_r};
      end
      OP_SPH: begin
        mul_a = div_q[63:24];
        mul_b = ratio;
      end
      OP_SPL: begin
        mul_a = {16'b0, freq_q[23:0]};
        mul_b = ratio;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = 72'(mul_a) * 72'(mul_b);
  end

  // Divider shared by the sample count scaling and the frequency.
  logic             div_start;
  logic [DIV_W-1:0] div_num, div_den;

  always_comb begin
    div_start = (cmd.op == OP_PK_DIV) || (cmd.op == OP_FDIV);
    if (cmd.op == OP_PK_DIV) begin
      div_num = {kh, 32'b0} + prod;
      div_den = {8'b0, den};
    end else begin
      div_num = {prod[55:0], 8'b0};
      div_den = {24'b0, total};
    end
  end

  ppsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Final speed and frequency with saturation.
  logic [40:0] speed_sum;
  logic [39:0] speed_sat, freq_sat;

  always_comb begin
    speed_sum = {1'b0, ph[31:0], 8'b0} + {1'b0, prod[55:16]};
    if ((ph[63:32] != '0) || speed_sum[40]) begin
      speed_sat = OUT_MAX;
    end else begin
      speed_sat = speed_sum[39:0];
    end
    freq_sat = (freq_q[63:40] != '0) ? OUT_MAX : freq_q[39:0];
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio     <= 32'd65536;
      timeout   <= 16'd60;
      var_en    <= 1'b0;
      low_rate  <= 16'd1;
      high_rate <= 16'd2;
      min_cnt   <= 7'd1;
      max_cnt   <= 7'd16;
      tick_hz   <= 32'd1000000;
      wp        <= '0;
      ring_vld  <= '0;
      stopped   <= 1'b1;
      last_cap  <= '0;
      last_ms   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATIO:   ratio     <= cfg_wdata;
          CFG_TIMEOUT: timeout   <= cfg_wdata[15:0];
          CFG_VAR_EN:  var_en    <= cfg_wdata[0];
          CFG_LOW:     low_rate  <= cfg_wdata[15:0];
          CFG_HIGH:    high_rate <= cfg_wdata[15:0];
          CFG_MIN:     min_cnt   <= cfg_wdata[6:0];
          CFG_MAX:     max_cnt   <= cfg_wdata[6:0];
          CFG_TICK:    tick_hz   <= cfg_wdata;
          default:     ratio     <= ratio;
        endcase
      end
      if (cmd.op == OP_CAPTURE) begin
        ring_vld[wp] <= 1'b1;
        wp           <= wp + 1'b1;
      end
      if (cmd.op == OP_DECIDE) begin
        stopped <= dec_stop;
        if (dec_wipe) begin
          ring_vld <= '0;
          wp       <= '0;
        end
        if (dec_lc_zero) begin
          last_cap <= '0;
        end else if (dec_seen) begin
          last_cap <= v_r;
        end
        if (dec_seen || dec_ms_now) begin
          last_ms <= now_r;
        end
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Evaluation payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START:   now_r <= in_data[63:32];
      OP_LATCH_V: v_r   <= entry;
      OP_DECIDE:  res_status <= dec_code;
      OP_WALK_INIT: begin
        cur_a    <= v_r;
        n_r      <= '0;
        want     <= want_init;
        walk_idx <= '0;
        total    <= '0;
        delta    <= '0;
        last     <= '0;
        last2    <= '0;
      end
      OP_WALK_STEP: begin
        cur_a    <= entry;
        walk_idx <= walk_idx + 1'b1;
        if (w_take) begin
          total <= tot1 + {8'b0, wd_new};
          last2 <= lastm;
          last  <= wd_new;
          delta <= wd_new;
          n_r   <= n_next;
        end
      end
      OP_PK_TMP: begin
        if (outlier(delta, last2)) begin
          tmp <= total - {8'b0, delta} + {8'b0, last2};
        end else begin
          tmp <= total;
        end
      end
      OP_PK_FN: prod <= mul_full[PROD_W-1:0];
      OP_PK_LO: begin
        fn_r <= prod[TOT_W-1:0];
        prod <= mul_full[PROD_W-1:0];
      end
      OP_PK_HI: begin
        lo_r <= prod[55:0];
        prod <= mul_full[PROD_W-1:0];
      end
      OP_PK_CMP: begin
        if (pk_direct) begin
          want <= pk_want;
        end
        num  <= {16'b0, fn_r} - lo_r;
        den  <= hi_v - lo_r;
        up_r <= max_cnt < min_cnt;
        k_r  <= (max_cnt < min_cnt) ? (min_cnt - max_cnt) : (max_cnt - min_cnt);
      end
      OP_PK_KH: prod <= mul_full[PROD_W-1:0];
      OP_PK_KL: begin
        kh   <= prod[31:0];
        prod <= mul_full[PROD_W-1:0];
      end
      OP_PK_SET: begin
        if (up_r) begin
          want <= {1'b0, min_cnt} - pk_adj;
        end else begin
          want <= {1'b0, min_cnt} + CNT_W'(div_q[6:0]);
        end
      end
      OP_FIX: begin
        if (outlier(delta, last) && outlier(delta, last2)) begin
          total <= total - {8'b0, delta} + {8'b0, last2};
        end
      end
      OP_CHK: res_status <= (n_r == '0) ? ST_NO_DELTAS : ST_BAD;
      OP_FMUL: prod <= mul_full[PROD_W-1:0];
      OP_SPH: begin
        freq_q <= div_q;
        prod   <= mul_full[PROD_W-1:0];
      end
      OP_SPL: begin
        ph   <= prod;
        prod <= mul_full[PROD_W-1:0];
      end
      OP_FOUT: begin
        res_status <= ST_OK;
        res_speed  <= speed_sat;
        res_freq   <= freq_sat;
      end
      OP_EMIT: begin
        out_status <= res_status;
        out_speed  <= (res_status == ST_OK) ? res_speed : 40'd0;
        out_freq   <= (res_status == ST_OK) ? res_freq : 40'd0;
      end
      default: begin
      end
    endcase
  end

  assign out_data = {out_freq, out_speed};

  // Status toward the controller.
  always_comb begin
    sts.dec_walk    = dec_walk;
    sts.want_zero   = want_init == '0;
    sts.walk_cont   = (n_next < want) && (walk_idx != WALK_W'(MAX_WALK - 1));
    sts.pick_now    = var_en && (32'(walk_idx) == 32'(min_cnt));
    sts.pick_direct = pk_direct;
    sts.walk_more   = (n_r < want) && (32'(walk_idx) < MAX_WALK);
    sts.n_zero      = n_r == '0;
    sts.total_zero  = total == '0;
    sts.div_done    = div_done;
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

### rtl/ppsm_ctrl.sv
// Controller state machine that sequences captures and evaluations.
module ppsm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  ppsm_pkg::sts_t sts,
  output ppsm_pkg::cmd_t cmd
);
  import ppsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid && in_func) state_next = S_RD1;
      S_RD1:     state_next = S_RDMIN;
      S_RDMIN:   state_next = S_DECIDE;
      S_DECIDE:  state_next = sts.dec_walk ? S_WINIT : S_EMIT;
      S_WINIT:   state_next = sts.want_zero ? S_FIX : S_WSTEP;
      S_WSTEP: begin
        if (sts.pick_now) begin
          state_next = S_PK_TMP;
        end else if (sts.walk_cont) begin
          state_next = S_WSTEP;
        end else begin
          state_next = S_FIX;
        end
      end
      S_PK_TMP:  state_next = S_PK_FN;
      S_PK_FN:   state_next = S_PK_LO;
      S_PK_LO:   state_next = S_PK_HI;
      S_PK_HI:   state_next = S_PK_CMP;
      S_PK_CMP:  state_next = sts.pick_direct ? S_PK_END : S_PK_KH;
      S_PK_KH:   state_next = S_PK_KL;
      S_PK_KL:   state_next = S_PK_DIV;
      S_PK_DIV:  state_next = S_PK_WAIT;
      S_PK_WAIT: if (sts.div_done) state_next = S_PK_SET;
      S_PK_SET:  state_next = S_PK_END;
      S_PK_END:  state_next = sts.walk_more ? S_WSTEP : S_FIX;
      S_FIX:     state_next = S_CHK;
      S_CHK:     state_next = (sts.n_zero || sts.total_zero) ? S_EMIT : S_FMUL;
      S_FMUL:    state_next = S_FDIV;
      S_FDIV:    state_next = S_FWAIT;
      S_FWAIT:   if (sts.div_done) state_next = S_SPH;
      S_SPH:     state_next = S_SPL;
      S_SPL:     state_next = S_FOUT;
      S_FOUT:    state_next = S_EMIT;
      S_EMIT:    if (sts.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs toward the datapath and the input channel.
  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.rd_sel = RD_BACK1;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = in_func ? OP_START : OP_CAPTURE;
      end
      S_RD1:     cmd.rd_sel = RD_BACK1;
      S_RDMIN: begin
        cmd.op     = OP_LATCH_V;
        cmd.rd_sel = RD_BACKMIN;
      end
      S_DECIDE:  cmd.op = OP_DECIDE;
      S_WINIT: begin
        cmd.op     = OP_WALK_INIT;
        cmd.rd_sel = RD_BACK2;
      end
      S_WSTEP: begin
        cmd.op     = OP_WALK_STEP;
        cmd.rd_sel = RD_WALK_NEXT;
      end
      S_PK_TMP:  cmd.op = OP_PK_TMP;
      S_PK_FN:   cmd.op = OP_PK_FN;
      S_PK_LO:   cmd.op = OP_PK_LO;
      S_PK_HI:   cmd.op = OP_PK_HI;
      S_PK_CMP:  cmd.op = OP_PK_CMP;
      S_PK_KH:   cmd.op = OP_PK_KH;
      S_PK_KL:   cmd.op = OP_PK_KL;
      S_PK_DIV:  cmd.op = OP_PK_DIV;
      S_PK_WAIT: cmd.op = OP_NONE;
      S_PK_SET:  cmd.op = OP_PK_SET;
      S_PK_END:  cmd.rd_sel = RD_WALK;
      S_FIX:     cmd.op = OP_FIX;
      S_CHK:     cmd.op = OP_CHK;
      S_FMUL:    cmd.op = OP_FMUL;
      S_FDIV:    cmd.op = OP_FDIV;
      S_FWAIT:   cmd.op = OP_NONE;
      S_SPH:     cmd.op = OP_SPH;
      S_SPL:     cmd.op = OP_SPL;
      S_FOUT:    cmd.op = OP_FOUT;
      S_EMIT:    if (sts.out_free) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/pulse_period_speed_meter_unit.sv
// Top level of the pulse period speed meter.
//
// A capture transfer (tuser low) stores its timestamp in the 64-entry ring. An evaluate
// transfer (tuser high) reads the ring and reaches the stop/stale decision; an early
// status (no new value, stopped, stale, unstopped) is then loaded into the output register.
// Otherwise a walk set-up state follows, then walk steps over the ring (up to 64, one ring
// read each). The sample-count scaling runs when variable sampling triggers it, and the
// frequency divide and speed scaling follow; both use the one-bit-per-cycle divider. A walk
// that finds no usable delta ends through the fix and check states. A result waits for the
// output register to drain before it is loaded. Only one evaluate is in flight; the input
// is not accepted until its result has been loaded into the output register. The ring is
// cleared through per-entry valid bits, so there is no clearing pass after reset. Speed
// and frequency are Q32.8 and are zero unless status is ok.
module pulse_period_speed_meter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,   // capture_value, now_ms
  input  logic                           s_axis_tuser,   // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [79:0]                    m_axis_tdata,   // speed, frequency
  output logic [2:0]                     m_axis_tuser,   // status
  input  logic                           cfg_we,
  input  logic [ppsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import ppsm_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_t out_status;

  ppsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppsm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_data   (m_axis_tdata)
  );

  assign m_axis_tuser = out_status;

endmodule

### rtl/ppsm_checker.sv
// Port-level checks on the speed meter output channel, bound to the top level.
module ppsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import ppsm_pkg::*;

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // Speed and frequency are zero unless status is ok.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("nonzero data with a non-ok status");

  // Status never carries the unused code.
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 3'd7)
    else $error("invalid status code");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind pulse_period_speed_meter_unit ppsm_checker u_ppsm_checker (.*);
